### hw/rtl/video_dirty_scanline_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the dirty scanline tracker
// ----------------------------------------------------------------------------
`ifndef VIDEO_DIRTY_SCANLINE_TRACKER_TOP_DEFINES_SVH
`define VIDEO_DIRTY_SCANLINE_TRACKER_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define VDST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define VDST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vdst_pkg.sv
// ----------------------------------------------------------------------------
// vdst_pkg
// types, codes and helper functions shared by the dirty scanline tracker
// ----------------------------------------------------------------------------
package vdst_pkg;

    // dirty map organisation
    localparam int GROUP_COUNT = 4;
    localparam int GROUP_WIDTH = 64;
    localparam int SWEEP_LIMIT = 256;
    localparam int QUEUE_DEPTH = 4;

    // operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_MARK    = 2'd1;
    localparam logic [1:0] OP_SWEEP   = 2'd2;
    localparam logic [1:0] OP_REFRESH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DISPLAY_MODE = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

    // register reset values and mode codes
    localparam logic signed [8:0] MODE_RESET    = 9'sd0;
    localparam logic [8:0]        HEIGHT_RESET  = 9'd200;
    localparam logic signed [8:0] MODE_CUSTOM   = -9'sd1;
    localparam logic signed [8:0] MODE_CGA_LOW  = 9'sd1;
    localparam logic signed [8:0] MODE_CGA_HIGH = 9'sd2;
    localparam logic signed [8:0] MODE_VGA_256  = 9'sd13;

    // video memory regions
    localparam logic [4:0] CGA_REGION = 5'b10111;  // 0xb8000 to 0xbffff
    localparam logic [3:0] EGA_REGION = 4'hA;      // 0xa0000 to 0xaffff
    localparam int ODD_BANK   = 32'h2000;
    localparam int BANK_BYTES = 8000;

    // divide by five: multiply by a reciprocal rounded up
    localparam logic [11:0] DIV5_MULT = 12'd3277;

    typedef struct packed {
        logic [1:0]  operation;
        logic [19:0] address;
        logic [9:0]  line;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  group_index;
        logic [63:0] redraw_mask;
        logic        decoded;
        logic        last;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_MARK,
        CMD_SWEEP,
        CMD_REFRESH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       in_map;
        logic [7:0] line;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

    // quotient of x / 5 for x below 4096
    function automatic logic [9:0] div5(input logic [11:0] x);
        logic [23:0] prod;
        prod = {12'b0, x} * {12'b0, DIV5_MULT};
        return prod[23:14];
    endfunction

    function automatic logic mode_active(input logic signed [8:0] mode);
        return (mode > 9'sd0) || (mode == MODE_CUSTOM);
    endfunction

    function automatic logic mode_decoded(input logic signed [8:0] mode);
        return (mode == MODE_CGA_LOW) || (mode == MODE_CGA_HIGH) || (mode == MODE_VGA_256);
    endfunction

    // lines of one group that sit below the sweep bound
    function automatic logic [GROUP_WIDTH-1:0] group_mask(input logic [8:0] bound,
                                                          input logic [1:0] grp);
        logic [GROUP_WIDTH-1:0] m;
        logic [8:0]             idx;
        m   = '0;
        idx = '0;
        for (int i = 0; i < GROUP_WIDTH; i++)
        begin
            idx  = {1'b0, grp, 6'(i)};
            m[i] = idx < bound;
        end
        return m;
    endfunction

endpackage

### hw/rtl/vdst_front.sv
// ----------------------------------------------------------------------------
// vdst_front
// accepts input words, maps write addresses to scanlines and queues commands
// ----------------------------------------------------------------------------
module vdst_front #(
    parameter int LINE_COUNT = 256
) (
    input  logic                 item_valid,
    output logic                 item_ready,
    input  vdst_pkg::in_word_t   item,
    input  logic signed [8:0]    display_mode,
    input  vdst_pkg::queue_status_t status,
    output logic                 push,
    output vdst_pkg::cmd_t       cmd
);
    import vdst_pkg::*;

    localparam logic [10:0] LINE_LIMIT = 11'(LINE_COUNT);

    logic [14:0] cga_rel;
    logic [14:0] odd_rel;
    logic        cga_hit;
    logic        ega_hit;
    logic        even_bank;
    logic        odd_bank;
    logic        map_ok;
    logic [11:0] div_in;
    logic [9:0]  quot;
    logic [9:0]  write_line;
    logic [9:0]  mark_line;
    logic        line_ok;
    logic        keep;
    cmd_kind_t   kind;

    // region decode
    always_comb
    begin
        cga_hit   = item.address[19:15] == CGA_REGION;
        ega_hit   = item.address[19:16] == EGA_REGION;
        cga_rel   = item.address[14:0];
        odd_rel   = cga_rel - 15'(ODD_BANK);
        even_bank = cga_rel < 15'(BANK_BYTES);
        odd_bank  = (cga_rel >= 15'(ODD_BANK)) && (cga_rel < 15'(ODD_BANK + BANK_BYTES));
        map_ok    = cga_hit ? (even_bank || odd_bank) : ega_hit;
    end

    // bytes per line: 80 is 16 x 5, 320 is 64 x 5
    always_comb
    begin
        priority if (cga_hit)
        begin
            div_in = even_bank ? {3'b0, cga_rel[12:4]} : {3'b0, odd_rel[12:4]};
        end
        else if (display_mode == MODE_VGA_256)
        begin
            div_in = {2'b0, item.address[15:6]};
        end
        else
        begin
            div_in = item.address[15:4];
        end
        quot       = div5(div_in);
        write_line = cga_hit ? {quot[8:0], ~even_bank} : quot;
    end

    // classify the word
    always_comb
    begin
        unique case (item.operation)
            OP_WRITE:
            begin
                kind      = CMD_MARK;
                mark_line = write_line;
                keep      = mode_active(display_mode) && map_ok;
            end
            OP_MARK:
            begin
                kind      = CMD_MARK;
                mark_line = item.line;
                keep      = 1'b1;
            end
            OP_SWEEP:
            begin
                kind      = CMD_SWEEP;
                mark_line = item.line;
                keep      = 1'b1;
            end
            OP_REFRESH:
            begin
                kind      = CMD_REFRESH;
                mark_line = item.line;
                keep      = 1'b1;
            end
            default:
            begin
                kind      = CMD_SWEEP;
                mark_line = item.line;
                keep      = 1'b0;
            end
        endcase
        line_ok = {1'b0, mark_line} < LINE_LIMIT;
    end

    // queue handshake; out-of-range marks are dropped here
    assign item_ready = !status.full;
    assign push       = item_valid && item_ready && keep && ((kind != CMD_MARK) || line_ok);
    assign cmd.kind   = kind;
    assign cmd.in_map = mark_line[9:8] == 2'b00;
    assign cmd.line   = mark_line[7:0];

endmodule

### hw/rtl/vdst_queue.sv
// ----------------------------------------------------------------------------
// vdst_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
module vdst_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  vdst_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output vdst_pkg::cmd_t          head,
    output vdst_pkg::queue_status_t status
);
    import vdst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);

endmodule

### hw/rtl/vdst_back.sv
// ----------------------------------------------------------------------------
// vdst_back
// holds the dirty map, executes queued commands and sweeps out redraw masks
// ----------------------------------------------------------------------------
module vdst_back #(
    parameter int LINE_COUNT = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vdst_pkg::queue_status_t status,
    input  vdst_pkg::cmd_t          head,
    output logic                    pop,
    input  logic signed [8:0]       display_mode,
    input  logic [8:0]              frame_height,
    output logic                    result_valid,
    input  logic                    result_ready,
    output vdst_pkg::out_word_t     result
);
    import vdst_pkg::*;

    localparam logic [10:0] LINE_LIMIT = 11'(LINE_COUNT);
    localparam logic [10:0] SWEEP_CAP  = 11'(SWEEP_LIMIT);
    localparam logic [1:0]  LAST_GROUP = 2'(GROUP_COUNT - 1);

    logic [GROUP_WIDTH-1:0] dirty_reg  [GROUP_COUNT];
    logic [GROUP_WIDTH-1:0] dirty_next [GROUP_COUNT];
    logic [GROUP_WIDTH-1:0] bmask      [GROUP_COUNT];
    logic [GROUP_WIDTH-1:0] eff        [GROUP_COUNT];
    logic                   pending_reg;
    logic                   pending_next;
    back_state_t            state_reg;
    back_state_t            state_next;
    logic [1:0]             group_reg;
    logic [1:0]             group_next;
    logic [GROUP_COUNT-1:0] nz_reg;
    logic [GROUP_COUNT-1:0] nz_next;
    logic [GROUP_COUNT-1:0] nz_start;
    logic [GROUP_COUNT-1:0] above;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_word_t              out_word_reg;
    out_word_t              out_word_next;
    logic [10:0]            bound_wide;
    logic [8:0]             bound;
    logic                   is_refresh;
    logic                   is_sweep;
    logic                   start_sweep;
    logic                   slot_free;
    logic [GROUP_WIDTH-1:0] scan_mask;
    logic                   scan_want;
    logic                   emit;
    logic                   last_flag;
    logic                   scan_done;

    // sweep bound: frame height clipped to line count and to four groups
    always_comb
    begin
        bound_wide = {2'b00, frame_height};
        if (bound_wide > LINE_LIMIT)
        begin
            bound_wide = LINE_LIMIT;
        end
        if (bound_wide > SWEEP_CAP)
        begin
            bound_wide = SWEEP_CAP;
        end
        bound = bound_wide[8:0];
    end

    // per-group masks and sweep lookahead
    always_comb
    begin
        is_refresh = head.kind == CMD_REFRESH;
        is_sweep   = (head.kind == CMD_SWEEP) || is_refresh;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            bmask[g]    = group_mask(bound, 2'(g));
            eff[g]      = dirty_reg[g] | (is_refresh ? bmask[g] : '0);
            nz_start[g] = |(eff[g] & bmask[g]);
            above[g]    = 2'(g) > group_reg;
        end
        start_sweep = mode_active(display_mode) && (pending_reg || is_refresh);
        pop         = (state_reg == ST_IDLE) && !status.empty;
        slot_free   = !out_valid_reg || result_ready;
        scan_mask   = dirty_reg[group_reg] & bmask[group_reg];
        scan_want   = (state_reg == ST_SCAN) && nz_reg[group_reg] && (scan_mask != '0);
        emit        = scan_want && slot_free;
        last_flag   = (nz_reg & above) == '0;
        scan_done   = (emit && last_flag) || (!scan_want && (group_reg == LAST_GROUP));
    end

    // next state
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && is_sweep && start_sweep && (nz_start != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                state_next = scan_done ? ST_IDLE : ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // dirty map, sweep progress and output register
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            dirty_next[g] = dirty_reg[g];
        end
        pending_next   = pending_reg;
        nz_next        = nz_reg;
        group_next     = group_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !result_ready;

        if (pop)
        begin
            unique case (head.kind)
                CMD_MARK:
                begin
                    if (head.in_map)
                    begin
                        dirty_next[head.line[7:6]][head.line[5:0]] = 1'b1;
                    end
                    pending_next = 1'b1;
                end
                CMD_SWEEP, CMD_REFRESH:
                begin
                    for (int g = 0; g < GROUP_COUNT; g++)
                    begin
                        dirty_next[g] = eff[g];
                    end
                    pending_next = pending_reg || is_refresh;
                    if (start_sweep)
                    begin
                        pending_next = 1'b0;
                        nz_next      = nz_start;
                        group_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
        begin
            out_word_next.group_index = group_reg;
            out_word_next.redraw_mask = scan_mask;
            out_word_next.decoded     = mode_decoded(display_mode);
            out_word_next.last        = last_flag;
            out_valid_next            = 1'b1;
            dirty_next[group_reg]     = dirty_reg[group_reg] & ~scan_mask;
            nz_next[group_reg]        = 1'b0;
        end

        // step to the next group unless stalled on the output
        if ((state_reg == ST_SCAN) && !scan_done && (emit || !scan_want))
        begin
            group_next = group_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                dirty_reg[g] <= '0;
            end
            pending_reg   <= 1'b0;
            state_reg     <= ST_IDLE;
            group_reg     <= '0;
            nz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                dirty_reg[g] <= dirty_next[g];
            end
            pending_reg   <= pending_next;
            state_reg     <= state_next;
            group_reg     <= group_next;
            nz_reg        <= nz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

### hw/rtl/video_dirty_scanline_tracker_top.sv
// a write or mark waits behind queued words, then the pop sets it in the registered dirty map
// a sweep or refresh, once popped, scans from group 0 and registers the first dirty group's mask
// scan visits one 64-line group a cycle unless stalled, empty ones up to the last dirty one too
// throughput: one word a cycle into a four-entry command queue while it is not full;
// the back end pops one a cycle while idle, and a sweep holds off its pops until the scan is done
// reset: asynchronous, active low; all lines clean, nothing pending, mode 0, height 200
// ----------------------------------------------------------------------------
// video_dirty_scanline_tracker_top
// dirty scanline tracker: config registers, front classifier, queue, back end
// ----------------------------------------------------------------------------
module video_dirty_scanline_tracker_top #(
    parameter int LINE_COUNT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  vdst_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output vdst_pkg::out_word_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);
    import vdst_pkg::*;

    logic signed [8:0] mode_reg;
    logic signed [8:0] mode_next;
    logic [8:0]        height_reg;
    logic [8:0]        height_next;
    logic              push;
    logic              pop;
    cmd_t              push_cmd;
    cmd_t              head;
    queue_status_t     status;

    // configuration write decode
    always_comb
    begin
        mode_next   = mode_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_MODE: mode_next   = $signed(cfg_data);
                CFG_FRAME_HEIGHT: height_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            height_reg <= height_next;
        end
    end

    // front: accept and classify
    vdst_front #(
        .LINE_COUNT (LINE_COUNT)
    ) u_front (
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .display_mode (mode_reg),
        .status       (status),
        .push         (push),
        .cmd          (push_cmd)
    );

    // command queue
    vdst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    // back end: dirty map and sweeps
    vdst_back #(
        .LINE_COUNT (LINE_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .head         (head),
        .pop          (pop),
        .display_mode (mode_reg),
        .frame_height (height_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### hw/rtl/vdst_checker.sv
// ----------------------------------------------------------------------------
// vdst_checker
// port-level assertions on the result channel of the tracker
// ----------------------------------------------------------------------------
`include "video_dirty_scanline_tracker_top_defines.svh"

module vdst_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input vdst_pkg::out_word_t result
);
    import vdst_pkg::*;

    // a stalled word holds
    `VDST_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result word changed")

    // nothing offered straight out of reset
    `VDST_ASSERT_SAME(a_reset_quiet, $rose(rst_n), !result_valid, "result valid right after reset")

    // empty groups are never reported
    `VDST_ASSERT_SAME(a_mask_nonzero, result_valid, result.redraw_mask != '0, "empty redraw mask reported")

    // the top group always closes a sweep
    `VDST_ASSERT_SAME(a_top_group_last, result_valid && (result.group_index == 2'd3), result.last, "top group not flagged last")

endmodule

bind video_dirty_scanline_tracker_top vdst_checker u_vdst_checker (.*);
